[rtl/core/assert_macros.svh]
// Assertion macros used by the top-level RTL file of the backlight dimmer.
// Each use expects i_clk and i_rst_n in scope. Synchronous active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define BID_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define BID_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/bid_pkg.sv]
// Package for the backlight inactivity dimmer: types, codes, constants
// and the clamp helpers for the configuration registers. No dependencies.
`timescale 1ns / 1ps

package bid_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int PCT_W      = 7;
    localparam int HOUR_W     = 5;
    localparam int MS_W       = 32;
    localparam int ADV_W      = 16;

    localparam logic [PCT_W-1:0]  PCT_MAX  = 7'd100;
    localparam logic [HOUR_W-1:0] HOUR_MAX = 5'd23;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LEVEL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIM_LEVEL    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIM_AFTER    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_AFTER    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NIGHT_EN     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_NIGHT_START  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_NIGHT_END    = 3'd6;

    // Reset values of the configuration registers
    localparam logic [PCT_W-1:0]  RST_ACTIVE_LEVEL = 7'd100;
    localparam logic [PCT_W-1:0]  RST_DIM_LEVEL    = 7'd30;
    localparam logic [MS_W-1:0]   RST_DIM_AFTER    = 32'd30000;
    localparam logic [MS_W-1:0]   RST_OFF_AFTER    = 32'd300000;
    localparam logic [HOUR_W-1:0] RST_NIGHT_START  = 5'd22;
    localparam logic [HOUR_W-1:0] RST_NIGHT_END    = 5'd6;

    typedef enum logic [1:0] {
        PWR_ACTIVE = 2'd0,
        PWR_DIM    = 2'd1,
        PWR_OFF    = 2'd2
    } t_power;

    typedef struct packed {
        logic [PCT_W-1:0]  active_level;
        logic [PCT_W-1:0]  dim_level;
        logic [MS_W-1:0]   dim_after_ms;
        logic [MS_W-1:0]   off_after_ms;
        logic              night_enable;
        logic [HOUR_W-1:0] night_start;
        logic [HOUR_W-1:0] night_end;
    } t_cfg;

    function automatic logic [PCT_W-1:0] clamp_pct(input logic [PCT_W-1:0] v);
        return (v > PCT_MAX) ? PCT_MAX : v;
    endfunction

    function automatic logic [HOUR_W-1:0] clamp_hour(input logic [HOUR_W-1:0] v);
        return (v > HOUR_MAX) ? HOUR_MAX : v;
    endfunction

endpackage

[rtl/core/bid_if.sv]
// Valid/ready channel interfaces for the backlight dimmer: one for the
// input word, one for the result word. Uses bid_pkg for field widths.
`timescale 1ns / 1ps

interface bid_in_if;
    logic                          valid;
    logic                          ready;
    logic                          mode;
    logic [bid_pkg::ADV_W-1:0]     advance_ms;
    logic [bid_pkg::HOUR_W-1:0]    hour_now;
    logic                          clock_synced;

    modport source (output valid, mode, advance_ms, hour_now, clock_synced, input ready);
    modport sink   (input valid, mode, advance_ms, hour_now, clock_synced, output ready);
endinterface

interface bid_out_if;
    logic                          valid;
    logic                          ready;
    logic [bid_pkg::PCT_W-1:0]     level;
    logic                          write_strobe;
    logic [1:0]                    power_state;

    modport source (output valid, level, write_strobe, power_state, input ready);
    modport sink   (input valid, level, write_strobe, power_state, output ready);
endinterface

[rtl/core/bid_cfg_regs.sv]
// Configuration register bank of the backlight dimmer: clamps written
// brightness and hour values. Depends on bid_pkg.
`timescale 1ns / 1ps

module bid_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [bid_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [bid_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output bid_pkg::t_cfg                   o_cfg
);

    bid_pkg::t_cfg r_cfg;
    bid_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                bid_pkg::REG_ACTIVE_LEVEL: begin
                    n_cfg.active_level = bid_pkg::clamp_pct(i_cfg_data[bid_pkg::PCT_W-1:0]);
                end
                bid_pkg::REG_DIM_LEVEL: begin
                    n_cfg.dim_level = bid_pkg::clamp_pct(i_cfg_data[bid_pkg::PCT_W-1:0]);
                end
                bid_pkg::REG_DIM_AFTER: begin
                    n_cfg.dim_after_ms = i_cfg_data[bid_pkg::MS_W-1:0];
                end
                bid_pkg::REG_OFF_AFTER: begin
                    n_cfg.off_after_ms = i_cfg_data[bid_pkg::MS_W-1:0];
                end
                bid_pkg::REG_NIGHT_EN: begin
                    n_cfg.night_enable = i_cfg_data[0];
                end
                bid_pkg::REG_NIGHT_START: begin
                    n_cfg.night_start = bid_pkg::clamp_hour(i_cfg_data[bid_pkg::HOUR_W-1:0]);
                end
                bid_pkg::REG_NIGHT_END: begin
                    n_cfg.night_end = bid_pkg::clamp_hour(i_cfg_data[bid_pkg::HOUR_W-1:0]);
                end
                default: begin
                    // unmapped index: drop the write
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.active_level <= bid_pkg::RST_ACTIVE_LEVEL;
            r_cfg.dim_level    <= bid_pkg::RST_DIM_LEVEL;
            r_cfg.dim_after_ms <= bid_pkg::RST_DIM_AFTER;
            r_cfg.off_after_ms <= bid_pkg::RST_OFF_AFTER;
            r_cfg.night_enable <= 1'b0;
            r_cfg.night_start  <= bid_pkg::RST_NIGHT_START;
            r_cfg.night_end    <= bid_pkg::RST_NIGHT_END;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/core/backlight_inactivity_dimmer.sv]
// Backlight inactivity dimmer, top level. A result word is registered and
// appears in the cycle after its input word is taken. Throughput: one word per
// cycle; the idle-time update (saturating add, then the dim/off compares) is
// combinational. Input halts only while a result word waits on a low ready.
// Reset (i_rst_n, synchronous, active low) restores register defaults, clears
// idle time and the activity flag, and marks the applied level unknown.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module backlight_inactivity_dimmer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [bid_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [bid_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    bid_in_if.sink                          i_item,
    bid_out_if.source                       o_result
);

    bid_pkg::t_cfg               w_cfg;

    logic [bid_pkg::MS_W-1:0]    r_idle_ms;
    logic                        r_activity_seen;
    logic [bid_pkg::PCT_W-1:0]   r_applied_level;
    logic                        r_applied_valid;

    logic                        r_out_valid;
    logic [bid_pkg::PCT_W-1:0]   r_out_level;
    logic                        r_out_strobe;
    bid_pkg::t_power             r_out_power;

    logic                        w_fire;
    logic [bid_pkg::MS_W:0]      w_sum;
    logic [bid_pkg::MS_W-1:0]    w_idle_tick;
    logic                        w_night;
    logic                        w_in_window;
    logic [bid_pkg::MS_W-1:0]    n_idle_ms;
    logic [bid_pkg::PCT_W-1:0]   n_level;
    bid_pkg::t_power             n_power;
    logic                        n_strobe;

    bid_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    assign i_item.ready = !r_out_valid || o_result.ready;
    assign w_fire       = i_item.valid && i_item.ready;

    always_comb begin
        w_sum       = {1'b0, r_idle_ms} + {{(bid_pkg::MS_W + 1 - bid_pkg::ADV_W){1'b0}},
                                           i_item.advance_ms};
        // hold at all ones instead of wrapping
        w_idle_tick = w_sum[bid_pkg::MS_W] ? {bid_pkg::MS_W{1'b1}} : w_sum[bid_pkg::MS_W-1:0];

        // window may wrap past midnight when start is after end
        if (w_cfg.night_start < w_cfg.night_end) begin
            w_in_window = (i_item.hour_now >= w_cfg.night_start) &&
                          (i_item.hour_now < w_cfg.night_end);
        end else begin
            w_in_window = (i_item.hour_now >= w_cfg.night_start) ||
                          (i_item.hour_now < w_cfg.night_end);
        end
        w_night = w_cfg.night_enable && i_item.clock_synced &&
                  (w_cfg.night_start != w_cfg.night_end) && w_in_window;

        if (i_item.mode) begin
            n_idle_ms = '0;
            n_level   = w_cfg.active_level;
            n_power   = bid_pkg::PWR_ACTIVE;
        end else begin
            n_idle_ms = w_idle_tick;
            if (!r_activity_seen ||
                ((w_cfg.dim_after_ms != '0) && (w_idle_tick < w_cfg.dim_after_ms))) begin
                n_level = w_cfg.active_level;
                n_power = bid_pkg::PWR_ACTIVE;
            end else if (w_night ||
                         ((w_cfg.off_after_ms != '0) && (w_idle_tick >= w_cfg.off_after_ms))) begin
                n_level = '0;
                n_power = bid_pkg::PWR_OFF;
            end else begin
                n_level = w_cfg.dim_level;
                n_power = bid_pkg::PWR_DIM;
            end
        end

        n_strobe = !r_applied_valid || (r_applied_level != n_level);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_ms       <= '0;
            r_activity_seen <= 1'b0;
            r_applied_level <= '0;
            r_applied_valid <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            if (w_fire) begin
                r_idle_ms       <= n_idle_ms;
                r_activity_seen <= r_activity_seen || i_item.mode;
                r_applied_level <= n_level;
                r_applied_valid <= 1'b1;
                r_out_valid     <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid     <= 1'b0;
            end
        end
    end

    // result payload: load with each accepted word
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_level  <= n_level;
            r_out_strobe <= n_strobe;
            r_out_power  <= n_power;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.level        = r_out_level;
    assign o_result.write_strobe = r_out_strobe;
    assign o_result.power_state  = r_out_power;

    `BID_ASSERT_NEXT(a_activity_clears_idle, w_fire && i_item.mode, r_idle_ms == '0, "idle time not cleared by activity")
    `BID_ASSERT_NEXT(a_fire_loads_result, w_fire, r_out_valid, "accepted word produced no result")
    `BID_ASSERT_NEXT(a_first_result_strobes, w_fire && !r_applied_valid, r_out_strobe, "first result after reset lacks write strobe")
    `BID_ASSERT_NOW(a_off_means_dark, r_out_valid && (r_out_power == bid_pkg::PWR_OFF), r_out_level == '0, "off state with nonzero level")

endmodule
